// ===== hw/rtl/battery_fault_window_monitor_top_defines.svh =====
// Assertion macros for the battery fault window monitor.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef BATTERY_FAULT_WINDOW_MONITOR_TOP_DEFINES_SVH
`define BATTERY_FAULT_WINDOW_MONITOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BFWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFWM_ASSERT(label, prop, msg)
`define BFWM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/bfwm_pkg.sv =====
// Types and constants of the battery fault window monitor.
// No dependencies; imported by the config interface and all modules.
`timescale 1ns / 1ps
`default_nettype none

package bfwm_pkg;

  localparam int NUM_COND  = 8;
  localparam int NUM_TIMED = 5;

  localparam logic [2:0] NORMAL_CODE = 3'd1;

  // state code per condition, index = fault_mask bit
  localparam logic [NUM_COND-1:0][2:0] COND_CODES =
    {3'd7, 3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0};

  // timed entries that use the temperature fault time
  localparam logic [NUM_TIMED-1:0] TEMP_TIMED = 5'b01100;

  localparam logic signed [15:0] CUR_NEUTRAL_LO = -16'sd30;
  localparam logic signed [15:0] CUR_NEUTRAL_HI = 16'sd30;
  localparam logic signed [15:0] CUR_HIGH_MAX   = 16'sd10000;
  localparam logic signed [17:0] SPREAD_MAX     = 18'sd50000;
  localparam logic signed [7:0]  TEMP_HIGH_MAX  = 8'sd120;
  localparam logic signed [7:0]  SENSOR_LO      = -8'sd1;
  localparam logic signed [7:0]  SENSOR_HI      = 8'sd1;

  localparam logic [15:0]        RST_VOLTAGE_LOW  = 16'd30000;
  localparam logic [15:0]        RST_VOLTAGE_HIGH = 16'd42200;
  localparam logic [15:0]        RST_UNBALANCE    = 16'd2000;
  localparam logic signed [7:0]  RST_TEMP_WARN    = 8'sd48;
  localparam logic signed [7:0]  RST_TEMP_HIGH    = 8'sd55;
  localparam logic [13:0]        RST_CURRENT_HIGH = 14'd2000;
  localparam logic [15:0]        RST_VOLT_TIME    = 16'd1000;
  localparam logic [15:0]        RST_TEMP_TIME    = 16'd1000;

  typedef enum logic [2:0] {
    CFG_VOLTAGE_LOW  = 3'd0,
    CFG_VOLTAGE_HIGH = 3'd1,
    CFG_UNBALANCE    = 3'd2,
    CFG_TEMP_WARN    = 3'd3,
    CFG_TEMP_HIGH    = 3'd4,
    CFG_CURRENT_HIGH = 3'd5,
    CFG_VOLT_TIME    = 3'd6,
    CFG_TEMP_TIME    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] pack_current;
    logic [15:0]        cell_v_high;
    logic [15:0]        cell_v_low;
    logic signed [7:0]  temp_max;
    logic signed [7:0]  temp_min;
  } sample_t;

  typedef struct packed {
    logic [15:0]        voltage_low_limit;
    logic [15:0]        voltage_high_limit;
    logic [15:0]        unbalance_limit;
    logic signed [7:0]  temp_warning_limit;
    logic signed [7:0]  temp_high_limit;
    logic [13:0]        current_high_limit;
    logic [15:0]        voltage_fault_time;
    logic [15:0]        temperature_fault_time;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          code;
    logic [NUM_COND-1:0] mask;
  } eval_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfwm_if.sv =====
// Channel interfaces of the battery fault window monitor: sample, result, config.
// Depends on bfwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfwm_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic signed [15:0] pack_current;
  logic [15:0]        cell_v_high;
  logic [15:0]        cell_v_low;
  logic signed [7:0]  temp_max;
  logic signed [7:0]  temp_min;

  modport source (output valid, now_ms, pack_current, cell_v_high, cell_v_low,
                  temp_max, temp_min, input ready);
  modport sink (input valid, now_ms, pack_current, cell_v_high, cell_v_low,
                temp_max, temp_min, output ready);
endinterface

interface bfwm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] state_code;
  logic [7:0] fault_mask;
  logic       efuse_on;

  modport source (output valid, state_code, fault_mask, efuse_on, input ready);
  modport sink (input valid, state_code, fault_mask, efuse_on, output ready);
endinterface

interface bfwm_cfg_if import bfwm_pkg::*;;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/battery_fault_window_monitor_top.sv =====
// Battery fault window monitor, top level: config registers, sample and result
// stages, persistence deadlines and efuse latch. Depends on bfwm_pkg, bfwm_if,
// bfwm_window and the assertion macro header.
//
// Usage:
//   in_ch  : one sample per transaction (time stamp, current, cell voltages,
//            temperatures), valid/ready.
//   out_ch : one result per sample: state code, fault mask, efuse state.
//   cfg_ch : register index and 16-bit data; always ready, write only while
//            no sample is in flight.
//   Stages: the result is registered in the result register after the sample
//   register, and a stall on out_ch can hold the sample between the two.
//   Throughput: one sample per cycle while out_ch does not stall; the compares
//   and the five 32-bit deadline adds sit between those registers.
//   When out_ch stalls, the result is held and one more sample may wait in
//   the sample register; in_ch.ready then drops until the result is taken.
//   Reset (rst_n low, synchronous) empties both stages, loads the default
//   limits and times, clears all persistence entries and closes the efuse.
//   Once tripped, the efuse stays open until reset.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_fault_window_monitor_top_defines.svh"

module battery_fault_window_monitor_top import bfwm_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  bfwm_in_if.sink     in_ch,
  bfwm_out_if.source  out_ch,
  bfwm_cfg_if.sink    cfg_ch
);

  cfg_t                  cfg_r;
  sample_t               s1_r;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  logic [2:0]            out_code_r;
  logic [NUM_COND-1:0]   out_mask_r;
  logic                  out_efuse_r;
  logic [NUM_TIMED-1:0][31:0] deadline_r;
  logic [NUM_TIMED-1:0][31:0] deadline_nxt;
  logic [NUM_TIMED-1:0]  armed_r;
  logic [NUM_TIMED-1:0]  armed_nxt;
  logic                  efuse_closed_r;
  logic                  efuse_closed_nxt;
  logic                  advance;
  logic                  in_accept;
  logic                  s1_go;
  sample_t               in_sample;
  eval_t                 eval;
  logic [NUM_TIMED-1:0]  trip;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign s1_go        = s1_valid_r && advance;
  assign cfg_ch.ready = 1'b1;

  assign in_sample.now_ms       = in_ch.now_ms;
  assign in_sample.pack_current = in_ch.pack_current;
  assign in_sample.cell_v_high  = in_ch.cell_v_high;
  assign in_sample.cell_v_low   = in_ch.cell_v_low;
  assign in_sample.temp_max     = in_ch.temp_max;
  assign in_sample.temp_min     = in_ch.temp_min;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_low_limit      <= RST_VOLTAGE_LOW;
      cfg_r.voltage_high_limit     <= RST_VOLTAGE_HIGH;
      cfg_r.unbalance_limit        <= RST_UNBALANCE;
      cfg_r.temp_warning_limit     <= RST_TEMP_WARN;
      cfg_r.temp_high_limit        <= RST_TEMP_HIGH;
      cfg_r.current_high_limit     <= RST_CURRENT_HIGH;
      cfg_r.voltage_fault_time     <= RST_VOLT_TIME;
      cfg_r.temperature_fault_time <= RST_TEMP_TIME;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_VOLTAGE_LOW:  cfg_r.voltage_low_limit      <= cfg_ch.data;
        CFG_VOLTAGE_HIGH: cfg_r.voltage_high_limit     <= cfg_ch.data;
        CFG_UNBALANCE:    cfg_r.unbalance_limit        <= cfg_ch.data;
        CFG_TEMP_WARN:    cfg_r.temp_warning_limit     <= cfg_ch.data[7:0];
        CFG_TEMP_HIGH:    cfg_r.temp_high_limit        <= cfg_ch.data[7:0];
        CFG_CURRENT_HIGH: cfg_r.current_high_limit     <= cfg_ch.data[13:0];
        CFG_VOLT_TIME:    cfg_r.voltage_fault_time     <= cfg_ch.data;
        CFG_TEMP_TIME:    cfg_r.temperature_fault_time <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sample stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_sample;
    end
  end

  bfwm_window u_window (
    .sample (s1_r),
    .cfg    (cfg_r),
    .result (eval)
  );

  // persistence: rearm when out of window, hold while in window
  always_comb begin
    logic [15:0] ftime;
    logic [31:0] dl;
    for (int i = 0; i < NUM_TIMED; i++) begin
      ftime = TEMP_TIMED[i] ? cfg_r.temperature_fault_time : cfg_r.voltage_fault_time;
      dl    = s1_r.now_ms + {16'd0, ftime};
      if (eval.mask[i+3] && armed_r[i]) begin
        deadline_nxt[i] = deadline_r[i];
      end else begin
        deadline_nxt[i] = dl;
      end
      armed_nxt[i] = eval.mask[i+3];
      trip[i]      = armed_nxt[i] && (deadline_nxt[i] <= s1_r.now_ms);
    end
    efuse_closed_nxt = efuse_closed_r && (trip == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r     <= '0;
      armed_r        <= '0;
      efuse_closed_r <= 1'b1;
    end else if (s1_go) begin
      deadline_r     <= deadline_nxt;
      armed_r        <= armed_nxt;
      efuse_closed_r <= efuse_closed_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_code_r  <= eval.code;
      out_mask_r  <= eval.mask;
      out_efuse_r <= efuse_closed_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.state_code = out_code_r;
  assign out_ch.fault_mask = out_mask_r;
  assign out_ch.efuse_on   = out_efuse_r;

  `BFWM_ASSERT(a_efuse_latched, !efuse_closed_r |=> !efuse_closed_r, "efuse reclosed without reset")
  `BFWM_ASSERT(a_armed_tracks_mask, s1_go |=> (armed_r == $past(eval.mask[NUM_COND-1:3])), "armed bits differ from window hits")
  `BFWM_ASSERT(a_open_result_latched, (out_valid_r && !out_efuse_r) |-> !efuse_closed_r, "open efuse reported while latch closed")
  `BFWM_ASSERT(a_normal_code, out_valid_r |-> ((out_mask_r == '0) == (out_code_r == NORMAL_CODE)), "state code disagrees with fault mask")
  `BFWM_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_r |-> in_ch.ready, "sample not taken while result stage empty")

endmodule

`default_nettype wire

// ===== hw/rtl/bfwm_window.sv =====
// Window comparators: fault mask and state code of one sample.
// Depends on bfwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfwm_window import bfwm_pkg::*; (
  input  sample_t sample,
  input  cfg_t    cfg,
  output eval_t   result
);

  logic signed [15:0]   cur;
  logic signed [7:0]    tmax;
  logic signed [7:0]    tmin;
  logic signed [17:0]   spread;
  logic signed [17:0]   unb;
  logic signed [15:0]   cur_hi_lim;
  logic signed [7:0]    twarn;
  logic signed [7:0]    thigh;
  logic [NUM_COND-1:0]  hit;
  logic [2:0]           code;

  assign cur        = sample.pack_current;
  assign tmax       = sample.temp_max;
  assign tmin       = sample.temp_min;
  assign twarn      = cfg.temp_warning_limit;
  assign thigh      = cfg.temp_high_limit;
  assign spread     = $signed({2'b00, sample.cell_v_high}) - $signed({2'b00, sample.cell_v_low});
  assign unb        = $signed({2'b00, cfg.unbalance_limit});
  assign cur_hi_lim = $signed({2'b00, cfg.current_high_limit});

  always_comb begin
    hit[0] = (cur >= CUR_NEUTRAL_LO) && (cur <= CUR_NEUTRAL_HI);
    hit[1] = (spread >= unb) && (spread <= SPREAD_MAX);
    hit[2] = (tmax >= twarn) && (tmax <= thigh);
    hit[3] = sample.cell_v_low <= cfg.voltage_low_limit;
    hit[4] = sample.cell_v_high >= cfg.voltage_high_limit;
    hit[5] = (tmax >= thigh) && (tmax <= TEMP_HIGH_MAX);
    hit[6] = (tmin >= SENSOR_LO) && (tmin <= SENSOR_HI);
    hit[7] = (cur >= cur_hi_lim) && (cur <= CUR_HIGH_MAX);
  end

  // last matching condition wins
  always_comb begin
    code = NORMAL_CODE;
    for (int i = 0; i < NUM_COND; i++) begin
      if (hit[i]) begin
        code = COND_CODES[i];
      end
    end
  end

  assign result.code = code;
  assign result.mask = hit;

endmodule

`default_nettype wire

// ===== dv/bfwm_trip_checker.sv =====
`timescale 1ns / 1ps
// Status checker for the battery fault window monitor: tracks the config
// writes, predicts the status of every accepted sample and compares each result.
// Depends on bfwm_pkg and the channel interfaces of bfwm_if.

module bfwm_trip_checker import bfwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bfwm_in_if   in_ch,
  bfwm_out_if  out_ch,
  bfwm_cfg_if  cfg_ch,
  output int   mismatches,
  output int   status_backlog
);

  localparam logic [2:0] CODE_NEUTRAL   = 3'd0;
  localparam logic [2:0] CODE_UNBALANCE = 3'd2;
  localparam logic [2:0] CODE_TEMP_WARN = 3'd3;
  localparam logic [2:0] CODE_UNDERVOLT = 3'd4;
  localparam logic [2:0] CODE_OVERVOLT  = 3'd5;
  localparam logic [2:0] CODE_OVERTEMP  = 3'd6;
  localparam logic [2:0] CODE_SENSOR    = 3'd6;
  localparam logic [2:0] CODE_OVERCUR   = 3'd7;

  // persistence entries timed by the temperature fault time
  localparam logic [4:0] TEMP_PERSIST = 5'b01100;

  typedef struct packed {
    logic [2:0] state_code;
    logic [7:0] fault_mask;
    logic       efuse_on;
  } status_t;

  cfg_t        limits;
  logic [31:0] deadline [NUM_TIMED];
  logic        armed [NUM_TIMED];
  logic        efuse_closed;
  status_t     pending_status [$];
  int          mismatch_count = 0;

  function automatic status_t predict_status(input sample_t s);
    int          cur, vh, vl, tmax, tmin;
    int          unb, tw, th, vlow, vhigh, chigh;
    logic [7:0]  hit;
    logic [31:0] due;
    status_t     st;
    cur   = $signed(s.pack_current);
    vh    = s.cell_v_high;
    vl    = s.cell_v_low;
    tmax  = $signed(s.temp_max);
    tmin  = $signed(s.temp_min);
    unb   = limits.unbalance_limit;
    tw    = $signed(limits.temp_warning_limit);
    th    = $signed(limits.temp_high_limit);
    vlow  = limits.voltage_low_limit;
    vhigh = limits.voltage_high_limit;
    chigh = limits.current_high_limit;

    hit[0] = cur >= -30 && cur <= 30;
    hit[1] = (vh - vl) >= unb && (vh - vl) <= 50000;
    hit[2] = tmax >= tw && tmax <= th;
    hit[3] = vl >= 0 && vl <= vlow;
    hit[4] = vh >= vhigh && vh <= 500000;
    hit[5] = tmax >= th && tmax <= 120;
    hit[6] = tmin >= -1 && tmin <= 1;
    hit[7] = cur >= chigh && cur <= 10000;

    st.state_code = NORMAL_CODE;
    if (hit[0]) st.state_code = CODE_NEUTRAL;
    if (hit[1]) st.state_code = CODE_UNBALANCE;
    if (hit[2]) st.state_code = CODE_TEMP_WARN;
    if (hit[3]) st.state_code = CODE_UNDERVOLT;
    if (hit[4]) st.state_code = CODE_OVERVOLT;
    if (hit[5]) st.state_code = CODE_OVERTEMP;
    if (hit[6]) st.state_code = CODE_SENSOR;
    if (hit[7]) st.state_code = CODE_OVERCUR;
    st.fault_mask = hit;

    // rearm while out of window, hold the deadline while in it
    for (int i = 0; i < NUM_TIMED; i++) begin
      due = s.now_ms + (TEMP_PERSIST[i] ? limits.temperature_fault_time
                                        : limits.voltage_fault_time);
      if (hit[i + 3]) begin
        if (!armed[i]) begin
          deadline[i] = due;
          armed[i] = 1'b1;
        end
      end else begin
        deadline[i] = due;
        armed[i] = 1'b0;
      end
    end
    for (int i = 0; i < NUM_TIMED; i++) begin
      if (armed[i] && deadline[i] <= s.now_ms) efuse_closed = 1'b0;
    end
    st.efuse_on = efuse_closed;
    return st;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    sample_t s;
    status_t want;
    if (!rst_n) begin
      limits.voltage_low_limit      = 16'd30000;
      limits.voltage_high_limit     = 16'd42200;
      limits.unbalance_limit        = 16'd2000;
      limits.temp_warning_limit     = 8'sd48;
      limits.temp_high_limit        = 8'sd55;
      limits.current_high_limit     = 14'd2000;
      limits.voltage_fault_time     = 16'd1000;
      limits.temperature_fault_time = 16'd1000;
      for (int i = 0; i < NUM_TIMED; i++) begin
        deadline[i] = '0;
        armed[i] = 1'b0;
      end
      efuse_closed = 1'b1;
      pending_status.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_VOLTAGE_LOW:  limits.voltage_low_limit      = cfg_ch.data;
          CFG_VOLTAGE_HIGH: limits.voltage_high_limit     = cfg_ch.data;
          CFG_UNBALANCE:    limits.unbalance_limit        = cfg_ch.data;
          CFG_TEMP_WARN:    limits.temp_warning_limit     = cfg_ch.data[7:0];
          CFG_TEMP_HIGH:    limits.temp_high_limit        = cfg_ch.data[7:0];
          CFG_CURRENT_HIGH: limits.current_high_limit     = cfg_ch.data[13:0];
          CFG_VOLT_TIME:    limits.voltage_fault_time     = cfg_ch.data;
          CFG_TEMP_TIME:    limits.temperature_fault_time = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_status.size() == 0) begin
          $error("result transaction with no sample outstanding");
          mismatch_count++;
        end else begin
          want = pending_status.pop_front();
          check_field("state_code", want.state_code, out_ch.state_code);
          check_field("fault_mask", want.fault_mask, out_ch.fault_mask);
          check_field("efuse_on", want.efuse_on, out_ch.efuse_on);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s.now_ms       = in_ch.now_ms;
        s.pack_current = in_ch.pack_current;
        s.cell_v_high  = in_ch.cell_v_high;
        s.cell_v_low   = in_ch.cell_v_low;
        s.temp_max     = in_ch.temp_max;
        s.temp_min     = in_ch.temp_min;
        pending_status.push_back(predict_status(s));
      end
    end
    mismatches     <= mismatch_count;
    status_backlog <= pending_status.size();
  end

endmodule

// ===== dv/battery_fault_window_monitor_top_tb.sv =====
`timescale 1ns / 1ps
// Top of the battery fault window monitor testbench: clock, reset, sample and
// config stimulus, result back-pressure and the verdict.
// Depends on bfwm_pkg, bfwm_if, the monitor RTL and bfwm_trip_checker.

module battery_fault_window_monitor_top_tb import bfwm_pkg::*;;

  localparam int RX_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 100;

  logic clk;
  logic rst_n;

  bfwm_in_if  in_if ();
  bfwm_out_if out_if ();
  bfwm_cfg_if cfg_if ();

  int mismatches;
  int status_backlog;

  bit          quiet = 1'b0;
  bit          rx_hold_req = 1'b0;
  logic [31:0] clock_ms;
  sample_t     last_sample;
  int          lim_vlow, lim_vhigh, lim_unb, lim_tw, lim_th, lim_chigh;

  battery_fault_window_monitor_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bfwm_trip_checker trip_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_if),
    .out_ch         (out_if),
    .cfg_ch         (cfg_if),
    .mismatches     (mismatches),
    .status_backlog (status_backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int near(input int b);
    return b + $urandom_range(0, 4) - 2;
  endfunction

  function automatic bit redraw(input int keep_pct);
    return $urandom_range(0, 99) >= keep_pct;
  endfunction

  function automatic sample_t next_sample(input sample_t prev, input int keep_pct);
    sample_t s;
    s = prev;
    s.now_ms = clock_ms;
    if (redraw(keep_pct)) begin
      case ($urandom_range(0, 4))
        0: s.pack_current = 16'(near($urandom_range(0, 1) ? 30 : -30));
        1: s.pack_current = 16'(near(lim_chigh));
        2: s.pack_current = 16'(near(10000));
        3: s.pack_current = 16'($urandom);
        default: s.pack_current = 16'($urandom_range(0, 80) - 40);
      endcase
    end
    if (redraw(keep_pct)) begin
      case ($urandom_range(0, 2))
        0: s.cell_v_low = 16'(near(lim_vlow));
        1: s.cell_v_low = 16'($urandom);
        default: s.cell_v_low = 16'($urandom_range(0, 3));
      endcase
    end
    if (redraw(keep_pct)) begin
      case ($urandom_range(0, 3))
        0: s.cell_v_high = 16'(near(lim_vhigh));
        1: s.cell_v_high = 16'(int'(s.cell_v_low) + near(lim_unb));
        2: s.cell_v_high = 16'(int'(s.cell_v_low) + near(50000));
        default: s.cell_v_high = 16'($urandom);
      endcase
    end
    if (redraw(keep_pct)) begin
      case ($urandom_range(0, 3))
        0: s.temp_max = 8'(near(lim_tw));
        1: s.temp_max = 8'(near(lim_th));
        2: s.temp_max = 8'(near(120));
        default: s.temp_max = 8'($urandom);
      endcase
    end
    if (redraw(keep_pct)) begin
      s.temp_min = $urandom_range(0, 1) ? 8'($urandom_range(0, 6) - 3) : 8'($urandom);
    end
    return s;
  endfunction

  task automatic offer_sample(input sample_t s);
    in_if.valid        <= 1'b1;
    in_if.now_ms       <= s.now_ms;
    in_if.pack_current <= s.pack_current;
    in_if.cell_v_high  <= s.cell_v_high;
    in_if.cell_v_low   <= s.cell_v_low;
    in_if.temp_max     <= s.temp_max;
    in_if.temp_min     <= s.temp_min;
    do @(posedge clk); while (!in_if.ready);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic offer_directed(input int cur, input int vh, input int vl,
                                input int tmax, input int tmin);
    sample_t s;
    s.now_ms       = clock_ms;
    s.pack_current = 16'(cur);
    s.cell_v_high  = 16'(vh);
    s.cell_v_low   = 16'(vl);
    s.temp_max     = 8'(tmax);
    s.temp_min     = 8'(tmin);
    clock_ms += 1;
    offer_sample(s);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (status_backlog != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_limits(input int vlow, input int vhigh, input int unb,
                                input int tw, input int th, input int chigh,
                                input int volt_time, input int temp_time);
    lim_vlow  = vlow;
    lim_vhigh = vhigh;
    lim_unb   = unb;
    lim_tw    = tw;
    lim_th    = th;
    lim_chigh = chigh;
    write_reg(CFG_VOLTAGE_LOW, 16'(vlow));
    write_reg(CFG_VOLTAGE_HIGH, 16'(vhigh));
    write_reg(CFG_UNBALANCE, 16'(unb));
    write_reg(CFG_TEMP_WARN, {8'($urandom), 8'(tw)});
    write_reg(CFG_TEMP_HIGH, {8'($urandom), 8'(th)});
    write_reg(CFG_CURRENT_HIGH, {2'($urandom), 14'(chigh)});
    write_reg(CFG_VOLT_TIME, 16'(volt_time));
    write_reg(CFG_TEMP_TIME, 16'(temp_time));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input int keep_pct, input int hold_at);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) rx_hold_req = 1'b1;
      clock_ms += $urandom_range(0, 20);
      last_sample = next_sample(last_sample, keep_pct);
      offer_sample(last_sample);
    end
  endtask

  initial begin : result_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int      tw;
    sample_t edge_time;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.now_ms       <= '0;
    in_if.pack_current <= '0;
    in_if.cell_v_high  <= '0;
    in_if.cell_v_low   <= '0;
    in_if.temp_max     <= '0;
    in_if.temp_min     <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_VOLTAGE_LOW;
    cfg_if.data        <= '0;
    lim_vlow  = 30000;
    lim_vhigh = 42200;
    lim_unb   = 2000;
    lim_tw    = 48;
    lim_th    = 55;
    lim_chigh = 2000;
    clock_ms  = $urandom_range(1000, 32'h7000_0000);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window edges under the default limits
    offer_directed(-30, 38000, 37000, 25, 20);
    offer_directed(30, 38000, 37000, 25, 20);
    offer_directed(-31, 38000, 37000, 25, 20);
    offer_directed(31, 38000, 37000, 25, 20);
    offer_directed(-32768, 0, 0, 25, 20);
    offer_directed(32767, 65535, 65535, 25, 20);
    offer_directed(2000, 40000, 38000, 25, 20);
    offer_directed(10000, 38000, 37000, 25, 20);
    offer_directed(10001, 38000, 37000, 25, 20);
    offer_directed(100, 50000, 0, 25, 20);
    offer_directed(100, 50001, 0, 25, 20);
    offer_directed(100, 0, 65535, 25, 20);
    offer_directed(100, 38000, 37000, 48, 20);
    offer_directed(100, 38000, 37000, 55, 20);
    offer_directed(100, 38000, 37000, 120, 20);
    offer_directed(100, 38000, 37000, 121, 20);
    offer_directed(100, 38000, 37000, -128, 20);
    offer_directed(100, 38000, 37000, 127, 20);
    offer_directed(100, 38000, 37000, 25, -1);
    offer_directed(100, 38000, 37000, 25, 1);
    offer_directed(100, 38000, 37000, 25, 2);
    offer_directed(100, 38000, 37000, 25, -128);
    offer_directed(100, 38000, 37000, 25, 127);
    // time stamp extremes with every timed condition out of window
    edge_time = '{32'hFFFF_FFFF, 16'sd100, 16'd38000, 16'd37000, 8'sd25, 8'sd20};
    offer_sample(edge_time);
    edge_time.now_ms = '0;
    offer_sample(edge_time);
    last_sample = edge_time;

    drain_results();
    tw = int'($urandom_range(0, 80)) - 20;
    program_limits($urandom_range(20000, 40000), $urandom_range(35000, 50000),
                   $urandom_range(0, 50000), tw, tw + int'($urandom_range(0, 40)),
                   $urandom_range(0, 10000), $urandom_range(20000, 65535),
                   $urandom_range(20000, 65535));
    run_random(PHASE_ITEMS, 50, -1);

    drain_results();
    program_limits(0, 0, 0, -128, -128, 0, 65535, 65535);
    run_random(PHASE_ITEMS, 50, -1);

    // limits above the fixed upper bounds: unbalance, overtemp, overcurrent empty
    drain_results();
    program_limits(65535, 65535, 65535, 127, 127, 16383, 65535, 65535);
    run_random(PHASE_ITEMS, 50, -1);

    // warning window inverted
    drain_results();
    program_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 50000), 100, -50, $urandom_range(0, 10000),
                   $urandom_range(40000, 65535), $urandom_range(40000, 65535));
    run_random(PHASE_ITEMS, 50, -1);

    // short persistence with slowly changing samples, receiver held off once
    drain_results();
    program_limits(30000, 42200, 2000, 48, 55, 2000,
                   $urandom_range(100, 400), $urandom_range(100, 400));
    run_random(PHASE_ITEMS, 90, 30);

    // zero persistence across the time stamp wrap, no idling from here on
    drain_results();
    quiet = 1'b1;
    tw = int'($urandom_range(0, 80)) - 20;
    program_limits($urandom_range(20000, 40000), $urandom_range(35000, 50000),
                   $urandom_range(0, 50000), tw, tw + int'($urandom_range(0, 40)),
                   $urandom_range(0, 10000), 0, 0);
    clock_ms = $urandom_range(32'hFFFF_FE00, 32'hFFFF_FFF0);
    run_random(PHASE_ITEMS, 70, -1);

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && status_backlog == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bfwm_pkg.sv
hw/rtl/bfwm_if.sv
hw/rtl/bfwm_window.sv
hw/rtl/battery_fault_window_monitor_top.sv
dv/bfwm_trip_checker.sv
dv/battery_fault_window_monitor_top_tb.sv
